[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a clock with an active-low reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds while reset is asserted
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cbms_pkg.sv]
// types and constants for the cosine best-match search block
`default_nettype none
package cbms_pkg;
    localparam int DOT_W   = 23;
    localparam int NORM_W  = 22;
    localparam int SCORE_W = 15;
    localparam int IDX_W   = 8;
    localparam int PROD_W  = 2 * NORM_W;
    localparam int LHS_W   = PROD_W + 2 * SCORE_W;
    localparam int MUL_W   = 2 * SCORE_W + NORM_W;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 15'h7fff;
    localparam logic [SCORE_W-1:0] THRESH_RESET = 15'd26214;
    localparam logic [0:0] ADDR_MATCH_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [7:0] query_element;
        logic signed [7:0] entry_element;
        logic              last_element;
        logic              last_entry;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   best_index;
        logic [SCORE_W-1:0] best_score;
        logic               matched;
    } t_out_item;

    typedef enum logic [6:0] {
        ST_ACC    = 7'b0000001,
        ST_PROD   = 7'b0000010,
        ST_SQ     = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_MUL_HI = 7'b0010000,
        ST_CMP    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

[rtl/cosine_best_match_search_top.sv]
// cosine best-match search: element accumulation and bit-serial score search
//
// Input channel carries element pairs of query and stored embedding plus
// last_element / last_entry flags. An element that is not the last of its
// vector is accumulated without a stall. On the last element the block
// stalls the input while a shared multiplier searches the Q0.15 score bit
// by bit: a product setup step, then for each of the 15 score bits a
// square, a low-half multiply, a high-half multiply and accumulate, and a
// compare, then a finish step; the single 30x22 multiplier is reused for
// every bit. The norm product is multiplied in two 22-bit halves.
// When last_entry is also set, one result transfer (best index, best score,
// match flag) is offered on the output channel; the output register holds it
// while the receiver stalls, and the next search's elements are accepted
// meanwhile. A new search end waits until that result is taken.
// Reset clears accumulators, best tracking and sets match_threshold to
// 26214; the configuration port is APB style with the threshold at 0.
`default_nettype none
module cosine_best_match_search_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire cbms_pkg::t_in_item  i_item,
    output logic                  o_valid,
    input  wire                   i_stall,
    output cbms_pkg::t_out_item   o_item,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [0:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import cbms_pkg::*;

    t_state r_state, n_state;
    logic [SCORE_W-1:0] r_thresh;
    logic [DOT_W-1:0]   r_dot;
    logic [NORM_W-1:0]  r_qn, r_en;
    logic [IDX_W-1:0]   r_cnt, r_best_idx;
    logic [SCORE_W-1:0] r_best, r_lo;
    logic               r_last_en;
    logic [PROD_W-1:0]  r_p;
    logic [LHS_W-1:0]   r_rhs;
    logic [2*SCORE_W-1:0] r_sq;
    logic [LHS_W-1:0]   r_lhs;
    logic [3:0]         r_bit;
    logic               r_ovalid;
    t_out_item          r_out;

    logic acc_in, cfg_wr;
    logic signed [15:0] qe, qq, ee;
    logic [DOT_W-1:0]  dot_nx;
    logic [NORM_W-1:0] qn_nx, en_nx;
    logic [SCORE_W-1:0] cand;
    logic [IDX_W-1:0] cnt_inc;
    logic [NORM_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_out;

    // stall while scoring, or at a search end while a result is pending
    assign o_stall = (r_state != ST_ACC) ||
                     (i_item.last_element && i_item.last_entry && r_ovalid);
    assign acc_in  = i_valid && !o_stall;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_MATCH_THRESHOLD) ? {17'd0, r_thresh} : 32'd0;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // element products and next accumulator values
    assign qe = i_item.query_element * i_item.entry_element;
    assign qq = i_item.query_element * i_item.query_element;
    assign ee = i_item.entry_element * i_item.entry_element;
    assign dot_nx = r_dot + DOT_W'($signed(qe));
    assign qn_nx  = r_qn + NORM_W'($unsigned(qq));
    assign en_nx  = r_en + NORM_W'($unsigned(ee));
    assign cand   = r_lo | (SCORE_W'(1) << r_bit);
    assign cnt_inc = (32'(r_cnt) + 32'd1 >= 32'(MAX_ENTRIES)) ? '0 : r_cnt + 1'b1;

    // shared multiplier: squared candidate times one half of the norm product
    assign mul_b   = (r_state == ST_MUL) ? r_p[NORM_W-1:0] : r_p[PROD_W-1:NORM_W];
    assign mul_out = MUL_W'(r_sq) * MUL_W'(mul_b);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC:    if (acc_in && i_item.last_element) n_state = ST_PROD;
            ST_PROD:   n_state = ST_SQ;
            ST_SQ:     n_state = ST_MUL;
            ST_MUL:    n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_CMP;
            ST_CMP:    n_state = (r_bit == 4'd0) ? ST_DONE : ST_SQ;
            ST_DONE:   n_state = ST_ACC;
            default:   n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_thresh <= THRESH_RESET;
            r_dot <= '0;
            r_qn <= '0;
            r_en <= '0;
            r_cnt <= '0;
            r_best_idx <= '0;
            r_best <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration write
            if (cfg_wr && paddr == ADDR_MATCH_THRESHOLD) r_thresh <= pwdata[SCORE_W-1:0];
            // output register release
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_ACC: if (acc_in) begin
                    r_dot <= dot_nx;
                    r_qn <= qn_nx;
                    r_en <= en_nx;
                    r_last_en <= i_item.last_entry;
                end
                ST_PROD: begin
                    // norm product and squared dot scaled by 2^30
                    r_p   <= PROD_W'(r_qn) * PROD_W'(r_en);
                    r_rhs <= LHS_W'(r_dot[DOT_W-2:0]) * LHS_W'(r_dot[DOT_W-2:0]) << 30;
                    r_lo  <= '0;
                    r_bit <= 4'(SCORE_W - 1);
                end
                ST_SQ:     r_sq <= (2*SCORE_W)'(cand) * (2*SCORE_W)'(cand);
                ST_MUL:    r_lhs <= LHS_W'(mul_out);
                ST_MUL_HI: r_lhs <= r_lhs + (LHS_W'(mul_out) << NORM_W);
                ST_CMP: begin
                    if (r_lhs <= r_rhs) r_lo <= cand;
                    r_bit <= r_bit - 4'd1;
                end
                ST_DONE: begin
                    logic [SCORE_W-1:0] sc;
                    logic [IDX_W-1:0]   bi;
                    logic [SCORE_W-1:0] bs;
                    sc = (r_qn == '0 || r_en == '0 || r_dot[DOT_W-1] || r_dot == '0)
                         ? '0 : r_lo;
                    bi = r_best_idx;
                    bs = r_best;
                    if (sc > r_best) begin
                        bi = r_cnt;
                        bs = sc;
                    end
                    r_dot <= '0;
                    r_qn <= '0;
                    r_en <= '0;
                    if (r_last_en) begin
                        r_out.best_index <= bi;
                        r_out.best_score <= bs;
                        r_out.matched    <= bs > r_thresh;
                        r_ovalid <= 1'b1;
                        r_cnt <= '0;
                        r_best_idx <= '0;
                        r_best <= '0;
                    end else begin
                        r_cnt <= cnt_inc;
                        r_best_idx <= bi;
                        r_best <= bs;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/cbms_checker.sv]
// port-level checks for the cosine best-match search block
`default_nettype none
`include "assert_macros.svh"
module cbms_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_valid,
    input wire i_stall,
    input wire pready,
    input wire cbms_pkg::t_out_item o_item
);
    import cbms_pkg::*;
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_item), "held result changed")
    `CHK_ASSERT(a_score_zero_idx, i_clk, i_rst_n, o_valid && o_item.best_score == '0 |-> o_item.best_index == '0, "index without score")
    `CHK_ASSERT(a_match_score, i_clk, i_rst_n, o_valid && o_item.matched |-> o_item.best_score != '0, "match with zero score")
    `CHK_ASSERT_ALWAYS(a_pready, i_clk, pready, "pready low")
endmodule
bind cosine_best_match_search_top cbms_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .pready(pready), .o_item(o_item)
);
`default_nettype wire
